### design/rlpe_pkg.sv
// Shared package of the RGB LED pulse encoder: word counts, register codes,
// reset values, the queue entry type and the divide-by-100 helper.
// No dependencies.
package rlpe_pkg;

  localparam int unsigned LEAD_WORDS     = 8;
  localparam int unsigned TAIL_WORDS     = 24;
  localparam int unsigned BITS_PER_PIXEL = 24;

  localparam int unsigned MAX_PHASE_A = (LEAD_WORDS > TAIL_WORDS) ? LEAD_WORDS : TAIL_WORDS;
  localparam int unsigned MAX_PHASE   =
    (MAX_PHASE_A > BITS_PER_PIXEL) ? MAX_PHASE_A : BITS_PER_PIXEL;
  localparam int unsigned CNT_W       = $clog2(MAX_PHASE);
  localparam int unsigned BIT_IDX_W   = $clog2(BITS_PER_PIXEL);

  localparam int unsigned PCT_W   = 7;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned PROD_W  = COLOR_W + PCT_W;

  // floor(x / 100) == (x * 5243) >> 19 for every product below 2^15.
  localparam int unsigned RECIP       = 5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned SCALED_W    = PROD_W + RECIP_W;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [PCT_W-1:0]  PCT_LIMIT       = 7'd70;
  localparam logic [PCT_W-1:0]  PCT_RESET       = 7'd47;
  localparam logic [DUTY_W-1:0] DUTY_ONE_RESET  = 16'd60;
  localparam logic [DUTY_W-1:0] DUTY_ZERO_RESET = 16'd30;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_DUTY_ONE   = 2'd1,
    REG_DUTY_ZERO  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [BITS_PER_PIXEL-1:0] grb;
    logic                      frame_start;
    logic                      frame_end;
  } pixel_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic logic [COLOR_W-1:0] div100(input logic [PROD_W-1:0] prod);
    logic [SCALED_W-1:0] m;
    m = SCALED_W'(prod) * SCALED_W'(RECIP);
    return m[RECIP_SHIFT +: COLOR_W];
  endfunction

endpackage

### design/rlpe_front.sv
// Front end of the RGB LED pulse encoder: accepts pixels and scales each
// channel by the brightness percentage. Depends on rlpe_pkg.
module rlpe_front import rlpe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [COLOR_W-1:0] red_i,
  input  logic [COLOR_W-1:0] green_i,
  input  logic [COLOR_W-1:0] blue_i,
  input  logic               frame_start_i,
  input  logic               frame_end_i,
  input  logic [PCT_W-1:0]   pct_i,
  output logic               wr_valid_o,
  output pixel_t             wr_data_o,
  input  logic               wr_ready_i
);

  logic              valid_q, valid_d;
  logic [PROD_W-1:0] prod_r_q, prod_g_q, prod_b_q;
  logic              start_q, end_q;
  logic              adv;

  // The product stage moves on when it is empty or the queue takes its pixel.
  assign adv   = !valid_q || wr_ready_i;
  assign full  = !adv;
  assign valid_d = adv ? push : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && push) begin
      prod_r_q <= PROD_W'(red_i) * PROD_W'(pct_i);
      prod_g_q <= PROD_W'(green_i) * PROD_W'(pct_i);
      prod_b_q <= PROD_W'(blue_i) * PROD_W'(pct_i);
      start_q  <= frame_start_i;
      end_q    <= frame_end_i;
    end
  end

  assign wr_valid_o            = valid_q;
  assign wr_data_o.grb         = {div100(prod_g_q), div100(prod_r_q), div100(prod_b_q)};
  assign wr_data_o.frame_start = start_q;
  assign wr_data_o.frame_end   = end_q;

endmodule

### design/rlpe_fifo.sv
// Short pixel queue between the front and back ends of the encoder.
// Depends on rlpe_pkg.
module rlpe_fifo import rlpe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_valid_i,
  input  pixel_t       wr_data_i,
  input  logic         rd_pop_i,
  output pixel_t       rd_data_o,
  output fifo_status_t status_o
);

  pixel_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, rptr_q;
  logic [FIFO_PTR_W:0]   cnt_q;
  logic                  do_wr, do_rd;

  assign status_o.full  = (cnt_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_wr = wr_valid_i && !status_o.full;
  assign do_rd = rd_pop_i && !status_o.empty;
  assign rd_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

### design/rlpe_back.sv
// Back end of the RGB LED pulse encoder: walks the lead, data and tail words
// of each queued pixel into a one-word output register. Depends on rlpe_pkg.
module rlpe_back import rlpe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fifo_status_t      q_status_i,
  input  pixel_t            q_data_i,
  output logic              q_pop_o,
  input  logic [DUTY_W-1:0] duty_one_i,
  input  logic [DUTY_W-1:0] duty_zero_i,
  output logic              empty,
  input  logic              pop,
  output logic [DUTY_W-1:0] duty_o,
  output logic              last_o
);

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DATA,
    PH_TAIL
  } phase_e;

  phase_e               phase_q, cur_phase, nxt_phase;
  logic [CNT_W-1:0]     cnt_q, cur_cnt, nxt_cnt;
  logic                 busy_q;
  pixel_t               job_q, cur;
  logic                 out_valid_q;
  logic [DUTY_W-1:0]    duty_q, word_duty;
  logic                 last_q, word_last;
  logic                 cur_valid, out_adv, emit;
  logic [BIT_IDX_W-1:0] bit_idx;

  // An idle sequencer works straight from the queue head, so the first word
  // of a pixel goes out in the same cycle the pixel leaves the queue.
  assign cur_valid = busy_q || !q_status_i.empty;
  assign cur       = busy_q ? job_q : q_data_i;
  assign cur_cnt   = busy_q ? cnt_q : '0;
  assign cur_phase = busy_q ? phase_q :
                     ((q_data_i.frame_start && (LEAD_WORDS != 0)) ? PH_LEAD : PH_DATA);
  assign out_adv   = !out_valid_q || pop;
  assign emit      = cur_valid && out_adv;
  assign q_pop_o   = emit && !busy_q;
  assign bit_idx   = BIT_IDX_W'(BITS_PER_PIXEL - 1) - BIT_IDX_W'(cur_cnt);

  always_comb begin
    word_duty = '0;
    word_last = 1'b0;
    nxt_phase = cur_phase;
    nxt_cnt   = cur_cnt + 1'b1;
    case (cur_phase)
      PH_LEAD: begin
        if (cur_cnt == CNT_W'(LEAD_WORDS - 1)) begin
          nxt_phase = PH_DATA;
          nxt_cnt   = '0;
        end
      end
      PH_DATA: begin
        word_duty = cur.grb[bit_idx] ? duty_one_i : duty_zero_i;
        if (cur_cnt == CNT_W'(BITS_PER_PIXEL - 1)) begin
          nxt_cnt = '0;
          if (cur.frame_end && (TAIL_WORDS != 0)) begin
            nxt_phase = PH_TAIL;
          end else begin
            word_last = 1'b1;
          end
        end
      end
      PH_TAIL: begin
        if (cur_cnt == CNT_W'(TAIL_WORDS - 1)) begin
          word_last = 1'b1;
          nxt_cnt   = '0;
        end
      end
      default: begin
        word_last = 1'b1;
        nxt_cnt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= PH_DATA;
      cnt_q       <= '0;
      job_q       <= '0;
      out_valid_q <= 1'b0;
      duty_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        duty_q      <= word_duty;
        last_q      <= word_last;
        busy_q      <= !word_last;
        job_q       <= cur;
        phase_q     <= nxt_phase;
        cnt_q       <= nxt_cnt;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty  = !out_valid_q;
  assign duty_o = duty_q;
  assign last_o = last_q;

endmodule

### design/rgb_led_pulse_encoder_unit.sv
// Top level of the RGB LED pulse encoder: configuration registers and the
// front end, pixel queue and back end. Depends on rlpe_pkg and its modules.
//
// Each pixel transfer (red, green, blue, frame flags) turns into 24 timer
// duty words, green then red then blue, most significant bit first: a set
// bit sends duty_one and a clear bit duty_zero, after each channel has been
// scaled to color * brightness_pct / 100 with truncation. A frame start puts
// 8 zero words in front of the data and a frame end puts 24 zero words after
// it; last_o marks the final word of each pixel. The output register hands
// out one word per cycle while pop is held high, so a pixel takes 24 words, or
// up to 56 with both flags set, and pixels stream without gaps between them.
// A pushed pixel passes one product stage before it is written to the queue
// (the reciprocal multiply sits on the queue's write side), and its first
// word is then registered from the queue head into the output register.
// The push side keeps accepting while a two-entry queue and the product
// stage have room. Configuration writes are always ready; a
// brightness above 70 is stored as 70, unknown indexes are ignored, and
// registers should only change while no pixel is in flight.
module rgb_led_pulse_encoder_unit import rlpe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [COLOR_W-1:0]   red_i,
  input  logic [COLOR_W-1:0]   green_i,
  input  logic [COLOR_W-1:0]   blue_i,
  input  logic                 frame_start_i,
  input  logic                 frame_end_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [DUTY_W-1:0]    duty_o,
  output logic                 last_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DUTY_W-1:0]    cfg_data_i
);

  logic [PCT_W-1:0]  pct_q;
  logic [DUTY_W-1:0] duty_one_q, duty_zero_q;
  logic [PCT_W-1:0]  pct_wr;
  logic              cfg_wr;

  logic         wr_valid;
  pixel_t       wr_data;
  pixel_t       q_data;
  logic         q_pop;
  fifo_status_t q_status;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign pct_wr      = (cfg_data_i[PCT_W-1:0] > PCT_LIMIT) ? PCT_LIMIT : cfg_data_i[PCT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q       <= PCT_RESET;
      duty_one_q  <= DUTY_ONE_RESET;
      duty_zero_q <= DUTY_ZERO_RESET;
    end else if (cfg_wr) begin
      if (cfg_index_i == REG_BRIGHTNESS) begin
        pct_q <= pct_wr;
      end
      if (cfg_index_i == REG_DUTY_ONE) begin
        duty_one_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_DUTY_ZERO) begin
        duty_zero_q <= cfg_data_i;
      end
    end
  end

  rlpe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .frame_start_i (frame_start_i),
    .frame_end_i   (frame_end_i),
    .pct_i         (pct_q),
    .wr_valid_o    (wr_valid),
    .wr_data_o     (wr_data),
    .wr_ready_i    (!q_status.full)
  );

  rlpe_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (wr_valid),
    .wr_data_i  (wr_data),
    .rd_pop_i   (q_pop),
    .rd_data_o  (q_data),
    .status_o   (q_status)
  );

  rlpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .duty_one_i  (duty_one_q),
    .duty_zero_i (duty_zero_q),
    .empty       (empty),
    .pop         (pop),
    .duty_o      (duty_o),
    .last_o      (last_o)
  );

endmodule

### design/rlpe_checker.sv
// Port-level checks for the RGB LED pulse encoder, bound to its top level.
// Depends on rlpe_pkg and rgb_led_pulse_encoder_unit.
module rlpe_checker import rlpe_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 push,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input logic [DUTY_W-1:0]    duty_o,
  input logic                 last_o,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o
);

  // A waiting word is not withdrawn before its transfer.
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result withdrawn before its transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(duty_o) && $stable(last_o))
    else $error("waiting result changed before its transfer");

  // Reset leaves no result waiting and the push side open once it has been
  // seen for a full cycle.
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni && $past(!rst_ni) |-> empty && !full)
    else $error("block not idle during reset");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind rgb_led_pulse_encoder_unit rlpe_checker u_rlpe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .duty_o      (duty_o),
  .last_o      (last_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

### test/rgb_led_pulse_encoder_unit_tb.sv
// Self-checking testbench for rgb_led_pulse_encoder_unit: pixel transfers in,
// timer duty words out, checked against a predictor kept in this file.
// Depends on rlpe_pkg and the encoder RTL only.
`timescale 1ns / 100ps

module rgb_led_pulse_encoder_unit_tb;
  import rlpe_pkg::*;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int unsigned PCT_DIVISOR  = 100;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 400;
  localparam int RUN_LIMIT_NS = 25_000_000;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              last;
  } led_word_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic [COLOR_W-1:0]   red_i;
  logic [COLOR_W-1:0]   green_i;
  logic [COLOR_W-1:0]   blue_i;
  logic                 frame_start_i;
  logic                 frame_end_i;
  logic                 empty;
  logic                 pop;
  logic [DUTY_W-1:0]    duty_o;
  logic                 last_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DUTY_W-1:0]    cfg_data_i;

  // Predicted register contents of the encoder.
  logic [PCT_W-1:0]  bright_pct;
  logic [DUTY_W-1:0] one_duty;
  logic [DUTY_W-1:0] zero_duty;

  // Duty words still owed by the encoder, oldest first.
  led_word_t pending_words[$];

  int error_count;
  int pixels_sent;
  int words_checked;
  int reg_writes;
  int push_stalls;

  // Idling controls shared between the test tasks and the result side.
  bit src_idle_en;
  bit sink_idle_en;
  bit long_hold_req;

  rgb_led_pulse_encoder_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .frame_start_i (frame_start_i),
    .frame_end_i   (frame_end_i),
    .empty         (empty),
    .pop           (pop),
    .duty_o        (duty_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Mirrors one register write. Brightness keeps only its low seven data bits
  // and saturates at the limit; an unmapped index leaves everything alone.
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [DUTY_W-1:0] data);
    logic [PCT_W-1:0] pct;
    pct = data[PCT_W-1:0];
    case (idx)
      REG_BRIGHTNESS: bright_pct = (pct > PCT_LIMIT) ? PCT_LIMIT : pct;
      REG_DUTY_ONE:   one_duty   = data;
      REG_DUTY_ZERO:  zero_duty  = data;
      default: ;
    endcase
  endfunction

  // Truncating brightness scale of one channel.
  function automatic logic [COLOR_W-1:0] scale_color(logic [COLOR_W-1:0] color);
    int unsigned prod;
    prod = int'(color) * int'(bright_pct);
    return COLOR_W'(prod / PCT_DIVISOR);
  endfunction

  function automatic void expect_word(logic [DUTY_W-1:0] duty, logic last);
    led_word_t w;
    w.duty = duty;
    w.last = last;
    pending_words.push_back(w);
  endfunction

  // Queues the words one accepted pixel must produce: optional lead zeros, the
  // 24 data words in green, red, blue order with the MSB first, then optional
  // tail zeros. Only the very last of them carries the last flag.
  function automatic void encode_pixel(logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                                       logic [COLOR_W-1:0] b, logic fs, logic fe);
    logic [BITS_PER_PIXEL-1:0] grb;
    grb = {scale_color(g), scale_color(r), scale_color(b)};
    if (fs) begin
      for (int i = 0; i < LEAD_WORDS; i++) expect_word('0, 1'b0);
    end
    for (int i = BITS_PER_PIXEL - 1; i >= 0; i--) begin
      expect_word(grb[i] ? one_duty : zero_duty, (i == 0) && !fe);
    end
    if (fe) begin
      for (int i = 0; i < TAIL_WORDS; i++) expect_word('0, i == TAIL_WORDS - 1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Mostly short pauses, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  // Drives pop. A long hold requested by a test is counted here, in cycles,
  // independent of what the sender is doing meanwhile.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        stall_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len() - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Every word transfer is compared with the oldest outstanding prediction.
  always @(posedge clk_i) begin
    led_word_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: duty %0d, last %0d", duty_o, last_o);
        error_count++;
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (duty_o !== want.duty) begin
          $error("duty: expected %0d, got %0d", want.duty, duty_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d words outstanding", pending_words.size());
    $display("rgb_led_pulse_encoder_unit_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Pixel and register transfers
  // ---------------------------------------------------------------------------

  // Offers one pixel and waits for its transfer. Push stays high afterwards so
  // that back-to-back pixels see no bubble; a random gap lowers it first.
  task automatic send_pixel(input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                            input logic [COLOR_W-1:0] b, input logic fs, input logic fe);
    int gap;
    gap = (src_idle_en && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push          <= 1'b1;
    red_i         <= r;
    green_i       <= g;
    blue_i        <= b;
    frame_start_i <= fs;
    frame_end_i   <= fe;
    @(posedge clk_i);
    while (full) begin
      push_stalls++;
      @(posedge clk_i);
    end
    encode_pixel(r, g, b, fs, fe);
    pixels_sent++;
  endtask

  // Drops push and waits until every predicted word has come out, then gives
  // the pipeline DRAIN_CYCLES further quiet cycles so that it is truly idle.
  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUTY_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, data);
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [COLOR_W-1:0] random_color();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Well-formed frames of a few pixels with random colors; about one pixel in
  // ten gets a scrambled start or end flag so that broken frames show up too.
  task automatic send_random_frames(input int count);
    int left;
    int len;
    logic fs;
    logic fe;
    left = count;
    while (left > 0) begin
      len = $urandom_range(1, 6);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        fs = (i == 0);
        fe = (i == len - 1);
        if ($urandom_range(0, 9) == 0) fs = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) fe = 1'($urandom_range(0, 1));
        send_pixel(random_color(), random_color(), random_color(), fs, fe);
      end
      left -= len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values of the registers, color extremes and every flag combination.
  task automatic test_reset_defaults();
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'h00, 1'b0, 1'b0);
    send_pixel(8'h00, 8'h80, 8'h01, 1'b0, 1'b1);
    send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1);
    send_pixel(8'h7F, 8'hFE, 8'h55, 1'b0, 1'b0);
    settle();
  endtask

  // Register extremes, brightness saturation and writes to the unmapped index.
  task automatic test_register_extremes();
    // All data bits set: brightness saturates at the limit.
    write_reg(REG_BRIGHTNESS, 16'hFFFF);
    write_reg(REG_DUTY_ONE, 16'hFFFF);
    write_reg(REG_DUTY_ZERO, 16'h0000);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
    send_pixel(8'hAA, 8'h55, 8'h81, 1'b1, 1'b1);
    settle();

    // Neither write may disturb the real registers.
    write_reg(REG_UNMAPPED, 16'hFFFF);
    write_reg(REG_UNMAPPED, 16'h0000);
    send_pixel(8'h0F, 8'hF0, 8'h3C, 1'b0, 1'b0);
    settle();

    // Upper data bits are ignored, so this is a brightness of zero.
    write_reg(REG_BRIGHTNESS, 16'hFF80);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
    settle();

    // Just above the limit.
    write_reg(REG_BRIGHTNESS, 16'd71);
    send_pixel(8'd200, 8'd100, 8'd50, 1'b0, 1'b1);
    settle();

    // Smallest nonzero brightness with the duty words swapped to the extremes.
    write_reg(REG_BRIGHTNESS, 16'd1);
    write_reg(REG_DUTY_ONE, 16'h0000);
    write_reg(REG_DUTY_ZERO, 16'hFFFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
    send_pixel(8'd99, 8'd100, 8'd101, 1'b0, 1'b0);
    settle();

    write_reg(REG_BRIGHTNESS, 16'd100);
    send_pixel(8'd143, 8'd7, 8'd255, 1'b1, 1'b1);
    settle();
  endtask

  // The result side stops for a long while as the sender keeps pushing
  // without gaps, so the internal queue fills and full must hold pixels off.
  task automatic test_input_backpressure();
    write_reg(REG_BRIGHTNESS, 16'd70);
    write_reg(REG_DUTY_ONE, 16'd60);
    write_reg(REG_DUTY_ZERO, 16'd30);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    long_hold_req = 1'b1;
    send_random_frames(12);
    settle();
  endtask

  // Random frames under several register settings and idling patterns.
  task automatic test_random_streams();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_BRIGHTNESS, 16'd127);
          write_reg(REG_DUTY_ONE, 16'hFFFF);
          write_reg(REG_DUTY_ZERO, 16'h0000);
          src_idle_en  = 1'b1;
          sink_idle_en = 1'b1;
        end
        1: begin
          // Everything scales to zero; streaming runs with no idling at all.
          write_reg(REG_BRIGHTNESS, 16'd0);
          src_idle_en  = 1'b0;
          sink_idle_en = 1'b0;
        end
        3: begin
          write_reg(REG_BRIGHTNESS, 16'd50);
          write_reg(REG_DUTY_ONE, 16'd60);
          write_reg(REG_DUTY_ZERO, 16'd30);
          src_idle_en  = 1'b0;
          sink_idle_en = 1'b1;
        end
        default: begin
          write_reg(REG_BRIGHTNESS, DUTY_W'($urandom_range(0, 16'hFFFF)));
          write_reg(REG_DUTY_ONE, DUTY_W'($urandom_range(0, 16'hFFFF)));
          write_reg(REG_DUTY_ZERO, DUTY_W'($urandom_range(0, 16'hFFFF)));
          src_idle_en  = 1'($urandom_range(0, 1));
          sink_idle_en = (phase == 2) ? 1'b1 : !src_idle_en;
        end
      endcase
      send_random_frames(56);
      settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        = 1'b0;
    push          = 1'b0;
    red_i         = '0;
    green_i       = '0;
    blue_i        = '0;
    frame_start_i = 1'b0;
    frame_end_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_BRIGHTNESS;
    cfg_data_i    = '0;
    bright_pct    = PCT_RESET;
    one_duty      = DUTY_ONE_RESET;
    zero_duty     = DUTY_ZERO_RESET;
    error_count   = 0;
    pixels_sent   = 0;
    words_checked = 0;
    reg_writes    = 0;
    push_stalls   = 0;
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    long_hold_req = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_input_backpressure();
    test_random_streams();
    settle();

    $display("covered %0d pixels and %0d duty words across %0d register writes",
             pixels_sent, words_checked, reg_writes);
    $display("push was held off by full for %0d cycles", push_stalls);
    if (error_count == 0) begin
      $display("rgb_led_pulse_encoder_unit_tb: done, clean");
    end else begin
      $display("rgb_led_pulse_encoder_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
